FILE: hdl/mprc_pkg.sv
package mprc_pkg;

  localparam int NumRegionsDef = 12;
  localparam int NumSubregions = 8;

  typedef enum logic [2:0] {
    OP_READ   = 3'd0,
    OP_WRITE  = 3'd1,
    OP_FETCH  = 3'd2,
    OP_SELECT = 3'd3,
    OP_BASE   = 3'd4,
    OP_SIZE   = 3'd5,
    OP_ATTR   = 3'd6,
    OP_NONE   = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    FK_NONE  = 3'd0,
    FK_ALIGN = 3'd1,
    FK_BG    = 3'd2,
    FK_PERM  = 3'd3,
    FK_XN    = 3'd4
  } fault_kind_t;

  localparam logic [1:0] CFG_PROT_EN = 2'd0;
  localparam logic [1:0] CFG_ALIGN   = 2'd1;
  localparam logic [1:0] CFG_BG_EN   = 2'd2;

  // classified request handed from front to back
  typedef struct packed {
    op_t         op;
    logic        hit_valid;
    logic [3:0]  region;
    logic        align_fault;
    logic        privileged;
    logic [31:0] value;
  } req_t;

  // ap code -> {priv read, priv write, user read, user write}
  function automatic logic [3:0] ap_perm(input logic [2:0] ap);
    logic [3:0] p;
    unique case (ap)
      3'd1:    p = 4'b1100;
      3'd2:    p = 4'b1110;
      3'd3:    p = 4'b1111;
      3'd5:    p = 4'b1000;
      3'd6:    p = 4'b1010;
      default: p = 4'b0000;
    endcase
    return p;
  endfunction

endpackage

FILE: hdl/mprc_front.sv
module mprc_front #(
  parameter int NUM_REGIONS = mprc_pkg::NumRegionsDef
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       take,
  input  logic [2:0]                 op,
  input  logic [31:0]                address,
  input  logic                       privileged,
  input  logic [31:0]                value,
  input  logic                       prot_en,
  input  logic                       align_en,
  input  logic [NUM_REGIONS*32-1:0]  base_flat,
  input  logic [NUM_REGIONS*5-1:0]   size_flat,
  input  logic [NUM_REGIONS-1:0]     en_flat,
  input  logic [NUM_REGIONS*8-1:0]   srd_flat,
  output logic                       q_valid,
  output mprc_pkg::req_t             q_req,
  input  logic                       q_pop
);
  import mprc_pkg::*;

  req_t       req;
  logic [NUM_REGIONS-1:0] match;
  logic [NUM_REGIONS-1:0] sub_ok;
  logic       q_valid_r, q_valid_nxt;
  req_t       q_req_r;

  // per-region address compare
  always_comb begin
    for (int r = 0; r < NUM_REGIONS; r++) begin
      logic [32:0] off;
      logic [4:0]  sz;
      logic [4:0]  sh;
      logic [32:0] len;
      logic [32:0] shifted;
      off = {1'b0, address} - {1'b0, base_flat[r*32 +: 32]};
      sz = size_flat[r*5 +: 5];
      len = 33'd1 << (6'(sz) + 6'd1);
      sh = (sz >= 5'd2) ? sz - 5'd2 : 5'd0;
      shifted = off >> sh;
      match[r] = en_flat[r] && (address >= base_flat[r*32 +: 32]) && (off < len);
      sub_ok[r] = !srd_flat[r*8 + 32'(shifted[2:0])];
    end
  end

  // highest matching region wins
  always_comb begin
    req = '0;
    req.op = op_t'(op);
    req.privileged = privileged;
    req.value = value;
    req.align_fault = align_en && (op != OP_FETCH) && (address[1:0] != 2'b00);
    for (int r = 0; r < NUM_REGIONS; r++) begin
      if (match[r]) begin
        req.region = 4'(r);
        req.hit_valid = sub_ok[r];
      end
    end
    if (!prot_en) begin
      req.align_fault = 1'b0;
    end
  end

  // one-entry queue to the back end
  always_comb begin
    q_valid_nxt = q_valid_r;
    if (q_pop) q_valid_nxt = 1'b0;
    if (take) q_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_valid_r <= 1'b0;
    end else begin
      q_valid_r <= q_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      q_req_r <= req;
    end
  end

  assign q_valid = q_valid_r;
  assign q_req = q_req_r;
endmodule

FILE: hdl/mprc_back.sv
module mprc_back #(
  parameter int NUM_REGIONS = mprc_pkg::NumRegionsDef
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_valid,
  input  mprc_pkg::req_t             q_req,
  output logic                       q_pop,
  input  logic                       prot_en,
  input  logic                       bg_en,
  output logic [NUM_REGIONS*32-1:0]  base_flat,
  output logic [NUM_REGIONS*5-1:0]   size_flat,
  output logic [NUM_REGIONS-1:0]     en_flat,
  output logic [NUM_REGIONS*8-1:0]   srd_flat,
  output logic                       out_valid,
  output logic                       out_fault,
  output logic [2:0]                 out_fault_kind,
  output logic [3:0]                 out_region_hit,
  output logic                       out_hit_valid,
  output logic                       out_write_rejected
);
  import mprc_pkg::*;

  localparam int IdxW = (NUM_REGIONS > 1) ? $clog2(NUM_REGIONS) : 1;

  logic [31:0] base_r [NUM_REGIONS];
  logic [4:0]  size_r [NUM_REGIONS];
  logic [NUM_REGIONS-1:0] en_r;
  logic [7:0]  srd_r [NUM_REGIONS];
  logic [2:0]  ap_r [NUM_REGIONS];
  logic [NUM_REGIONS-1:0] xn_r;
  logic [3:0]  cur_r;
  logic        cur_ok;
  logic        v_r;
  logic        fault_r;
  logic [2:0]  kind_r;
  logic [3:0]  hit_r;
  logic        hv_r;
  logic        rej_r;
  logic        fault_c;
  fault_kind_t kind_c;
  logic        rej_c;
  logic [3:0]  perm;
  logic [4:0]  new_sz;

  assign q_pop = q_valid;
  assign cur_ok = 32'(cur_r) < NUM_REGIONS;
  assign new_sz = q_req.value[5:1];
  assign perm = ap_perm(ap_r[q_req.region[IdxW-1:0]]);

  // fault decision
  always_comb begin
    fault_c = 1'b0;
    kind_c = FK_NONE;
    rej_c = 1'b0;
    priority case (1'b1)
      (q_req.op == OP_READ || q_req.op == OP_WRITE || q_req.op == OP_FETCH): begin
        if (prot_en) begin
          if (q_req.align_fault) begin
            fault_c = 1'b1; kind_c = FK_ALIGN;
          end else if (!q_req.hit_valid) begin
            if (!(q_req.privileged && bg_en)) begin
              fault_c = 1'b1; kind_c = FK_BG;
            end
          end else if (q_req.op == OP_FETCH) begin
            if (xn_r[q_req.region[IdxW-1:0]]) begin
              fault_c = 1'b1; kind_c = FK_XN;
            end
          end else begin
            if (!perm[{q_req.privileged, q_req.op == OP_READ}]) begin
              fault_c = 1'b1; kind_c = FK_PERM;
            end
          end
        end
      end
      (q_req.op == OP_SELECT): rej_c = !(q_req.value < 32'(NUM_REGIONS));
      (q_req.op == OP_BASE || q_req.op == OP_ATTR): rej_c = !cur_ok;
      (q_req.op == OP_SIZE): rej_c = (new_sz < 5'd4) || !cur_ok;
      default: rej_c = 1'b0;
    endcase
  end

  // region register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r <= '0;
      en_r <= '0;
      xn_r <= '0;
      for (int r = 0; r < NUM_REGIONS; r++) begin
        base_r[r] <= '0;
        size_r[r] <= '0;
        srd_r[r] <= '0;
        ap_r[r] <= '0;
      end
    end else if (q_valid && !rej_c) begin
      for (int r = 0; r < NUM_REGIONS; r++) begin
        if (cur_r == 4'(r)) begin
          if (q_req.op == OP_BASE) base_r[r] <= q_req.value;
          if (q_req.op == OP_SIZE) begin
            size_r[r] <= new_sz;
            en_r[r] <= q_req.value[0];
            srd_r[r] <= q_req.value[15:8];
          end
          if (q_req.op == OP_ATTR) begin
            ap_r[r] <= q_req.value[10:8];
            xn_r[r] <= q_req.value[12];
          end
        end
      end
      if (q_req.op == OP_SELECT) cur_r <= q_req.value[3:0];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (q_valid) begin
      fault_r <= fault_c;
      kind_r <= kind_c;
      rej_r <= rej_c;
      hv_r <= prot_en && (q_req.op == OP_READ || q_req.op == OP_WRITE ||
              q_req.op == OP_FETCH) && !q_req.align_fault && q_req.hit_valid;
      hit_r <= q_req.region;
    end
  end

  always_comb begin
    for (int r = 0; r < NUM_REGIONS; r++) begin
      base_flat[r*32 +: 32] = base_r[r];
      size_flat[r*5 +: 5] = size_r[r];
      srd_flat[r*8 +: 8] = srd_r[r];
    end
  end

  assign en_flat = en_r;
  assign out_valid = v_r;
  assign out_fault = fault_r;
  assign out_fault_kind = kind_r;
  assign out_hit_valid = hv_r;
  assign out_region_hit = hv_r ? hit_r : 4'd0;
  assign out_write_rejected = rej_r;
endmodule

FILE: hdl/memory_protection_region_check_top.sv
// flow: a check or region write is accepted, classified into a one-entry queue,
// then resolved; the back end's result register strobes out_valid
// busy holds off a new request while the previous one sits in the queue,
// so region writes land before the next lookup; receiver cannot stall
// reset: synchronous active-low; all regions disabled, config registers cleared
module memory_protection_region_check_top #(
  parameter int NUM_REGIONS = mprc_pkg::NumRegionsDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_op,
  input  logic [31:0] in_address,
  input  logic        in_privileged,
  input  logic [31:0] in_value,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic        cfg_data,
  output logic        out_valid,
  output logic        out_fault,
  output logic [2:0]  out_fault_kind,
  output logic [3:0]  out_region_hit,
  output logic        out_hit_valid,
  output logic        out_write_rejected
);
  import mprc_pkg::*;

  logic prot_en_r, align_r, bg_r;
  logic q_valid, q_pop, take;
  req_t q_req;
  logic [NUM_REGIONS*32-1:0] base_flat;
  logic [NUM_REGIONS*5-1:0]  size_flat;
  logic [NUM_REGIONS-1:0]    en_flat;
  logic [NUM_REGIONS*8-1:0]  srd_flat;

  assign busy = q_valid;
  assign take = start && !busy;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prot_en_r <= 1'b0;
      align_r <= 1'b0;
      bg_r <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_PROT_EN) prot_en_r <= cfg_data;
      if (cfg_index == CFG_ALIGN) align_r <= cfg_data;
      if (cfg_index == CFG_BG_EN) bg_r <= cfg_data;
    end
  end

  mprc_front #(.NUM_REGIONS(NUM_REGIONS)) u_front (
    .clk, .rst_n, .take,
    .op(in_op), .address(in_address), .privileged(in_privileged), .value(in_value),
    .prot_en(prot_en_r), .align_en(align_r),
    .base_flat, .size_flat, .en_flat, .srd_flat,
    .q_valid, .q_req, .q_pop
  );

  mprc_back #(.NUM_REGIONS(NUM_REGIONS)) u_back (
    .clk, .rst_n, .q_valid, .q_req, .q_pop,
    .prot_en(prot_en_r), .bg_en(bg_r),
    .base_flat, .size_flat, .en_flat, .srd_flat,
    .out_valid, .out_fault, .out_fault_kind, .out_region_hit,
    .out_hit_valid, .out_write_rejected
  );
endmodule

FILE: verif/memory_protection_region_check_checker.sv
module memory_protection_region_check_checker #(
  parameter int NUM_REGIONS = mprc_pkg::NumRegionsDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [2:0]  in_op,
  input  logic [31:0] in_address,
  input  logic        in_privileged,
  input  logic [31:0] in_value,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic        cfg_data,
  input  logic        out_valid,
  input  logic        out_fault,
  input  logic [2:0]  out_fault_kind,
  input  logic [3:0]  out_region_hit,
  input  logic        out_hit_valid,
  input  logic        out_write_rejected,
  output int          errors,
  output int          pending
);
  import mprc_pkg::*;

  typedef struct packed {
    logic        fault;
    fault_kind_t kind;
    logic [3:0]  hit;
    logic        hit_valid;
    logic        rejected;
  } verdict_t;

  // shadow of the protection unit
  logic        prot_en, align_en, bg_en;
  logic [31:0] base_q   [NUM_REGIONS];
  logic [4:0]  size_q   [NUM_REGIONS];
  logic        enab_q   [NUM_REGIONS];
  logic [7:0]  srd_q    [NUM_REGIONS];
  logic [2:0]  ap_q     [NUM_REGIONS];
  logic        xn_q     [NUM_REGIONS];
  logic [3:0]  cur_region;

  verdict_t verdicts_due[$];

  // resolve one request and update the shadow registers
  function automatic verdict_t resolve_request(op_t op, logic [31:0] addr, logic priv,
                                               logic [31:0] val);
    verdict_t    v;
    bit          found, sub_off, can_rd, can_wr;
    int          r, sel;
    logic [63:0] len, off;
    int          sh;
    logic [2:0]  sub;
    logic [4:0]  sz;
    v = '0;
    v.kind = FK_NONE;
    case (op)
      OP_READ, OP_WRITE, OP_FETCH: begin
        if (prot_en) begin
          if (align_en && op != OP_FETCH && addr[1:0] != 2'b00) begin
            v.fault = 1'b1;
            v.kind = FK_ALIGN;
          end else begin
            found = 0;
            sub_off = 0;
            sel = 0;
            // highest enabled region wins
            for (r = NUM_REGIONS - 1; r >= 0; r--) begin
              len = 64'd1 << (size_q[r] + 1);
              if (!found && enab_q[r] && {32'd0, addr} >= {32'd0, base_q[r]}
                  && ({32'd0, addr} - {32'd0, base_q[r]}) < len) begin
                found = 1;
                sel = r;
                off = {32'd0, addr} - {32'd0, base_q[r]};
                sh = (size_q[r] >= 2) ? size_q[r] - 2 : 0;
                sub = 3'(off >> sh);
                sub_off = srd_q[r][sub];
              end
            end
            if (!found || sub_off) begin
              if (!(priv && bg_en)) begin
                v.fault = 1'b1;
                v.kind = FK_BG;
              end
            end else begin
              v.hit = 4'(sel);
              v.hit_valid = 1'b1;
              if (op == OP_FETCH) begin
                if (xn_q[sel]) begin
                  v.fault = 1'b1;
                  v.kind = FK_XN;
                end
              end else begin
                // ap table, privileged and user columns
                case (ap_q[sel])
                  3'd1: begin can_rd = priv; can_wr = priv; end
                  3'd2: begin can_rd = 1; can_wr = priv; end
                  3'd3: begin can_rd = 1; can_wr = 1; end
                  3'd5: begin can_rd = priv; can_wr = 0; end
                  3'd6: begin can_rd = 1; can_wr = 0; end
                  default: begin can_rd = 0; can_wr = 0; end
                endcase
                if ((op == OP_READ) ? !can_rd : !can_wr) begin
                  v.fault = 1'b1;
                  v.kind = FK_PERM;
                end
              end
            end
          end
        end
      end
      OP_SELECT: begin
        if (val < NUM_REGIONS) cur_region = val[3:0];
        else v.rejected = 1'b1;
      end
      OP_BASE: base_q[cur_region] = val;
      OP_SIZE: begin
        sz = val[5:1];
        if (sz < 5'd4) begin
          v.rejected = 1'b1;
        end else begin
          size_q[cur_region] = sz;
          enab_q[cur_region] = val[0];
          srd_q[cur_region] = val[15:8];
        end
      end
      OP_ATTR: begin
        xn_q[cur_region] = val[12];
        ap_q[cur_region] = val[10:8];
      end
      default: ;
    endcase
    return v;
  endfunction

  assign pending = verdicts_due.size();

  // track requests, config writes and results
  always @(posedge clk) begin
    verdict_t exp_v;
    if (!rst_n) begin
      prot_en = 0;
      align_en = 0;
      bg_en = 0;
      cur_region = '0;
      for (int i = 0; i < NUM_REGIONS; i++) begin
        base_q[i] = '0;
        size_q[i] = '0;
        enab_q[i] = 0;
        srd_q[i] = '0;
        ap_q[i] = '0;
        xn_q[i] = 0;
      end
      verdicts_due.delete();
      errors <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_PROT_EN: prot_en = cfg_data;
          CFG_ALIGN:   align_en = cfg_data;
          CFG_BG_EN:   bg_en = cfg_data;
          default: ;
        endcase
      end
      if (out_valid) begin
        if (verdicts_due.size() == 0) begin
          $display("%0t: unexpected result fault=%0b kind=%0d hit=%0d hv=%0b rej=%0b",
                   $time, out_fault, out_fault_kind, out_region_hit, out_hit_valid,
                   out_write_rejected);
          errors <= errors + 1;
        end else begin
          exp_v = verdicts_due.pop_front();
          if (exp_v != {out_fault, out_fault_kind, out_region_hit, out_hit_valid,
                        out_write_rejected}) begin
            $display("%0t: mismatch expected fault=%0b kind=%0d hit=%0d hv=%0b rej=%0b",
                     $time, exp_v.fault, exp_v.kind, exp_v.hit, exp_v.hit_valid,
                     exp_v.rejected);
            $display("%0t:          actual   fault=%0b kind=%0d hit=%0d hv=%0b rej=%0b",
                     $time, out_fault, out_fault_kind, out_region_hit, out_hit_valid,
                     out_write_rejected);
            errors <= errors + 1;
          end
        end
      end
      if (start && !busy)
        verdicts_due.push_back(resolve_request(op_t'(in_op), in_address, in_privileged,
                                               in_value));
    end
  end

endmodule

FILE: verif/tb_memory_protection_region_check_top.sv
module tb_memory_protection_region_check_top;
  import mprc_pkg::*;

  localparam int NREG = NumRegionsDef;
  localparam int StallLimit = 3000;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [2:0]  in_op;
  logic [31:0] in_address;
  logic        in_privileged;
  logic [31:0] in_value;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic        cfg_data;
  logic        out_valid;
  logic        out_fault;
  logic [2:0]  out_fault_kind;
  logic [3:0]  out_region_hit;
  logic        out_hit_valid;
  logic        out_write_rejected;
  int          errors;
  int          pending;
  int          stall_cnt;
  int          n_requests;
  bit          gaps_on;

  // regions as programmed, used to aim addresses
  logic [31:0] aim_base [NREG];
  logic [4:0]  aim_size [NREG];

  memory_protection_region_check_top dut (.*);

  memory_protection_region_check_checker #(.NUM_REGIONS(NREG)) u_checker (.*);

  // clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // watchdog on stalled progress
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cnt <= 0;
    end else begin
      stall_cnt <= stall_cnt + 1;
      if (stall_cnt >= StallLimit) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // issue one request; returns at the edge that accepts it
  task automatic send_request(op_t op, logic [31:0] addr, logic priv, logic [31:0] val);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    start <= 1'b1;
    in_op <= op;
    in_address <= addr;
    in_privileged <= priv;
    in_value <= val;
    do @(negedge clk); while (busy);
    @(posedge clk);
    n_requests++;
  endtask

  // let every request resolve, then write all three registers
  task automatic write_config(logic pe, logic al, logic bg);
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_PROT_EN;
    cfg_data <= pe;
    @(posedge clk);
    cfg_index <= CFG_ALIGN;
    cfg_data <= al;
    @(posedge clk);
    cfg_index <= CFG_BG_EN;
    cfg_data <= bg;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // full region setup sequence with random content
  task automatic program_region(int r, logic [31:0] b, logic [4:0] sz, logic en,
                                logic [7:0] srd, logic [2:0] ap, logic xn);
    logic [31:0] w;
    send_request(OP_SELECT, $urandom, 1'($urandom), 32'(r));
    send_request(OP_BASE, $urandom, 1'($urandom), b);
    w = $urandom;
    w[0] = en;
    w[5:1] = sz;
    w[15:8] = srd;
    send_request(OP_SIZE, $urandom, 1'($urandom), w);
    w = $urandom;
    w[10:8] = ap;
    w[12] = xn;
    send_request(OP_ATTR, $urandom, 1'($urandom), w);
    aim_base[r] = b;
    if (sz >= 4) aim_size[r] = sz;
  endtask

  function automatic logic [31:0] aimed_address();
    int          r;
    logic [63:0] len, off;
    r = $urandom_range(0, NREG - 1);
    len = 64'd1 << (aim_size[r] + 1);
    off = {$urandom, $urandom} % (len + 64'd8);
    return aim_base[r] + off[31:0] - ($urandom_range(0, 3) == 0 ? 32'd4 : 32'd0);
  endfunction

  initial begin
    int          k, pick, sz;
    logic [31:0] b, a;
    rst_n = 1'b0;
    start = 1'b0;
    in_op = OP_READ;
    in_address = '0;
    in_privileged = 1'b0;
    in_value = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_PROT_EN;
    cfg_data = 1'b0;
    gaps_on = 1'b0;
    n_requests = 0;
    for (k = 0; k < NREG; k++) begin
      aim_base[k] = '0;
      aim_size[k] = 5'd4;
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // unit disabled: everything passes
    send_request(OP_READ, 32'hFFFF_FFFF, 1'b0, '0);
    send_request(OP_FETCH, 32'h0000_0001, 1'b1, '0);
    send_request(OP_NONE, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
    // bad region number and bad size
    send_request(OP_SELECT, '0, 1'b0, NREG);
    send_request(OP_SELECT, '0, 1'b0, 32'hFFFF_FFFF);
    send_request(OP_SIZE, '0, 1'b0, 32'h0000_FF07);
    // whole-space region 0, a small top region with a disabled subregion
    program_region(0, 32'h0, 5'd31, 1'b1, 8'h00, 3'd2, 1'b1);
    program_region(NREG - 1, 32'hFFFF_FF00, 5'd7, 1'b1, 8'h80, 3'd3, 1'b0);
    write_config(1'b1, 1'b1, 1'b0);
    send_request(OP_READ, 32'h0000_0002, 1'b1, '0);
    send_request(OP_FETCH, 32'h0000_0002, 1'b0, '0);
    send_request(OP_WRITE, 32'h1000_0000, 1'b0, '0);
    send_request(OP_READ, 32'h1000_0000, 1'b0, '0);
    send_request(OP_FETCH, 32'hFFFF_FF00, 1'b0, '0);
    send_request(OP_WRITE, 32'hFFFF_FFFC, 1'b0, '0);
    write_config(1'b1, 1'b0, 1'b1);
    send_request(OP_READ, 32'hFFFF_FFFF, 1'b1, '0);
    send_request(OP_READ, 32'hFFFF_FFFF, 1'b0, '0);

    // random phases over all config settings
    for (int ph = 0; ph < 8; ph++) begin
      write_config(ph[0], ph[1], ph[2]);
      gaps_on = (ph != 7);
      for (int i = 0; i < 160; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 4) begin
          sz = ($urandom_range(0, 4) == 0) ? $urandom_range(4, 31) : $urandom_range(4, 12);
          b = $urandom;
          if ($urandom_range(0, 1)) b = b & ~((32'd1 << (sz + 1)) - 1);
          program_region($urandom_range(0, NREG - 1), b, 5'(sz),
                         $urandom_range(0, 4) != 0,
                         ($urandom_range(0, 1) ? 8'h00 : 8'($urandom)), 3'($urandom),
                         1'($urandom));
        end else if (pick < 10) begin
          // noise on the region registers, bad numbers and sizes included
          send_request(op_t'($urandom_range(3, 7)), $urandom, 1'($urandom),
                       $urandom_range(0, 1) ? $urandom : $urandom_range(0, 20));
        end else begin
          a = (pick < 80) ? aimed_address() : $urandom;
          send_request(op_t'($urandom_range(0, 2)), a, 1'($urandom), $urandom);
        end
      end
    end

    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    $display("covered %0d requests over 8 protection/alignment/background settings",
             n_requests);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: memory_protection_region_check_top.f
hdl/mprc_pkg.sv
hdl/mprc_front.sv
hdl/mprc_back.sv
hdl/memory_protection_region_check_top.sv
verif/memory_protection_region_check_checker.sv
verif/tb_memory_protection_region_check_top.sv
